/* rtl/drtm_pkg.sv */
`default_nettype none
package drtm_pkg;

	// descriptor geometry
	localparam int DESC_LEN   = 128;
	localparam int LANES      = 8;
	localparam int MAX_REFS   = 4096;
	localparam int ELEM_FIELDS = 8;
	localparam int USED_LANES = (LANES < ELEM_FIELDS) ? LANES : ELEM_FIELDS;
	localparam int NUM_ROWS   = (DESC_LEN + LANES - 1) / LANES;
	localparam int LAST_CHUNK = NUM_ROWS - 1;
	localparam int ROW_W      = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;

	// field widths
	localparam int ELEM_W   = 8;
	localparam int CHUNK_W  = 4;
	localparam int INDEX_W  = 12;
	localparam int POS_W    = CHUNK_W + $clog2(LANES + 1) + 1;
	localparam int SQ_W     = 2 * ELEM_W;
	localparam int SUM_W    = SQ_W + $clog2(USED_LANES + 1);
	localparam int PART_W   = 24;
	localparam int DIST_W   = 27;
	localparam int BEST_W   = 23;
	localparam int WEIGHT_W = 8;
	localparam int PROD_W   = WEIGHT_W + DIST_W;

	localparam logic [DIST_W-1:0]   NO_DIST           = DIST_W'(100000000);
	localparam logic [WEIGHT_W-1:0] BEST_WEIGHT_RST   = WEIGHT_W'(10 * 10);
	localparam logic [WEIGHT_W-1:0] SECOND_WEIGHT_RST = WEIGHT_W'(6 * 6);

	// result queue
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BEST_WEIGHT   = 1'b0,
		REG_SECOND_WEIGHT = 1'b1
	} cfg_reg_t;

	// request kinds
	localparam logic REQ_QUERY = 1'b0;
	localparam logic REQ_REF   = 1'b1;

	typedef logic [ELEM_W-1:0] elem_t;
	typedef elem_t [USED_LANES-1:0] row_t;
	typedef logic [USED_LANES-1:0] lane_mask_t;

	typedef struct packed {
		logic                req_type;
		logic [CHUNK_W-1:0]  chunk;
		logic [INDEX_W-1:0]  ref_index;
		logic                last_ref;
		elem_t               elem_0;
		elem_t               elem_1;
		elem_t               elem_2;
		elem_t               elem_3;
		elem_t               elem_4;
		elem_t               elem_5;
		elem_t               elem_6;
		elem_t               elem_7;
	} in_beat_t;

	typedef struct packed {
		logic                match_found;
		logic [INDEX_W-1:0]  best_index;
		logic [BEST_W-1:0]   best_dist;
		logic [DIST_W-1:0]   second_dist;
	} out_beat_t;

	// per-beat control traveling down the pipe
	typedef struct packed {
		logic                valid;
		logic                is_ref;
		logic                last_chunk;
		logic                last_ref;
		logic [INDEX_W-1:0]  ref_index;
	} stage_ctl_t;

	// search outcome handed to the ratio stage
	typedef struct packed {
		logic                valid;
		logic [INDEX_W-1:0]  index;
		logic [DIST_W-1:0]   best;
		logic [DIST_W-1:0]   second;
	} hit_t;

endpackage
`default_nettype wire

/* rtl/drtm_if.sv */
`default_nettype none
interface drtm_in_if;
	logic               valid;
	logic               ready;
	drtm_pkg::in_beat_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface drtm_out_if;
	logic                valid;
	logic                ready;
	drtm_pkg::out_beat_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/drtm_query_mem.sv */
`default_nettype none
module drtm_query_mem (
	input  wire logic                          clk,
	input  wire logic                          wr_en,
	input  wire drtm_pkg::lane_mask_t          lane_we,
	input  wire logic                          rd_en,
	input  wire logic [drtm_pkg::ROW_W-1:0]    addr,
	input  wire drtm_pkg::row_t                wr_data,
	output      drtm_pkg::row_t                rd_data
);

	drtm_pkg::row_t mem [drtm_pkg::NUM_ROWS];

	always_ff @(posedge clk) begin
		for (int i = 0; i < drtm_pkg::USED_LANES; i++) begin
			if (wr_en && lane_we[i]) begin
				mem[addr][i] <= wr_data[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[addr];
		end
	end

endmodule
`default_nettype wire

/* rtl/drtm_dist.sv */
`default_nettype none
module drtm_dist (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire drtm_pkg::stage_ctl_t          ctl_s1,
	input  wire drtm_pkg::row_t                elem_s1,
	input  wire drtm_pkg::lane_mask_t          lane_ok_s1,
	input  wire drtm_pkg::row_t                qry_s1,
	output      drtm_pkg::stage_ctl_t          ctl_s2,
	output      logic [drtm_pkg::SUM_W-1:0]    sum_s2
);

	logic [drtm_pkg::SUM_W-1:0] sum;

	// sum of squared lane differences, masked lanes add nothing
	always_comb begin
		logic [drtm_pkg::ELEM_W-1:0] diff;
		logic [drtm_pkg::SQ_W-1:0]   sq;
		sum = '0;
		for (int i = 0; i < drtm_pkg::USED_LANES; i++) begin
			diff = (elem_s1[i] > qry_s1[i]) ? (elem_s1[i] - qry_s1[i])
			                                : (qry_s1[i] - elem_s1[i]);
			sq = drtm_pkg::SQ_W'(diff) * drtm_pkg::SQ_W'(diff);
			if (lane_ok_s1[i]) begin
				sum = sum + drtm_pkg::SUM_W'(sq);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		sum_s2 <= sum;
	end

endmodule
`default_nettype wire

/* rtl/drtm_search.sv */
`default_nettype none
module drtm_search (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire drtm_pkg::stage_ctl_t          ctl_s2,
	input  wire logic [drtm_pkg::SUM_W-1:0]    sum_s2,
	output      drtm_pkg::hit_t                hit_s3
);

	logic [drtm_pkg::PART_W-1:0]  partial_q, partial_n;
	logic [drtm_pkg::DIST_W-1:0]  best_q, best_n;
	logic [drtm_pkg::DIST_W-1:0]  second_q, second_n;
	logic [drtm_pkg::INDEX_W-1:0] closest_q, closest_n;
	drtm_pkg::hit_t               hit;

	always_comb begin
		logic [drtm_pkg::PART_W-1:0] acc;
		logic [drtm_pkg::DIST_W-1:0] dsq;
		acc = partial_q + drtm_pkg::PART_W'(sum_s2);
		dsq = drtm_pkg::DIST_W'(acc);
		partial_n = partial_q;
		best_n    = best_q;
		second_n  = second_q;
		closest_n = closest_q;
		hit       = '0;
		if (ctl_s2.valid) begin
			if (!ctl_s2.is_ref) begin
				partial_n = '0;
				best_n    = drtm_pkg::NO_DIST;
				second_n  = drtm_pkg::NO_DIST;
				closest_n = '0;
			end else begin
				partial_n = acc;
				if (ctl_s2.last_chunk) begin
					partial_n = '0;
					// strict compare: a tie keeps the earlier reference
					if (dsq < best_q) begin
						second_n  = best_q;
						best_n    = dsq;
						closest_n = ctl_s2.ref_index;
					end else if (dsq < second_q) begin
						second_n = dsq;
					end
					if (ctl_s2.last_ref) begin
						hit.valid  = 1'b1;
						hit.index  = closest_n;
						hit.best   = best_n;
						hit.second = second_n;
						best_n     = drtm_pkg::NO_DIST;
						second_n   = drtm_pkg::NO_DIST;
						closest_n  = '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			best_q    <= drtm_pkg::NO_DIST;
			second_q  <= drtm_pkg::NO_DIST;
			closest_q <= '0;
			hit_s3    <= '0;
		end else begin
			partial_q <= partial_n;
			best_q    <= best_n;
			second_q  <= second_n;
			closest_q <= closest_n;
			hit_s3    <= hit;
		end
	end

endmodule
`default_nettype wire

/* rtl/drtm_ratio.sv */
`default_nettype none
module drtm_ratio (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire drtm_pkg::hit_t                 hit_s3,
	input  wire logic [drtm_pkg::WEIGHT_W-1:0]  best_weight,
	input  wire logic [drtm_pkg::WEIGHT_W-1:0]  second_weight,
	output      logic                           res_valid,
	output      drtm_pkg::out_beat_t            res
);

	drtm_pkg::hit_t               hit_s4;
	logic [drtm_pkg::PROD_W-1:0]  lhs_s4;
	logic [drtm_pkg::PROD_W-1:0]  rhs_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s4 <= '0;
		end else begin
			hit_s4 <= hit_s3;
		end
	end

	always_ff @(posedge clk) begin
		lhs_s4 <= drtm_pkg::PROD_W'(best_weight) * drtm_pkg::PROD_W'(hit_s3.best);
		rhs_s4 <= drtm_pkg::PROD_W'(second_weight) * drtm_pkg::PROD_W'(hit_s3.second);
	end

	always_comb begin
		res_valid        = hit_s4.valid;
		res.match_found  = lhs_s4 < rhs_s4;
		res.best_index   = hit_s4.index;
		res.best_dist    = hit_s4.best[drtm_pkg::BEST_W-1:0];
		res.second_dist  = hit_s4.second;
	end

endmodule
`default_nettype wire

/* rtl/drtm_out_fifo.sv */
`default_nettype none
module drtm_out_fifo (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire drtm_pkg::out_beat_t   push_data,
	drtm_out_if.source                 result
);

	drtm_pkg::out_beat_t               mem [drtm_pkg::FIFO_DEPTH];
	logic [drtm_pkg::FIFO_AW-1:0]      wr_ptr_q;
	logic [drtm_pkg::FIFO_AW-1:0]      rd_ptr_q;
	logic [drtm_pkg::CNT_W-1:0]        count_q;
	logic                              pop;

	// never overflows: the top level holds input once every slot is owed
	assign pop          = result.valid && result.ready;
	assign result.valid = (count_q != '0);
	assign result.data  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/descriptor_ratio_test_matcher.sv */
`default_nettype none
// Nearest-neighbor ratio-test matcher. Load a 128-element query with
// req_type 0 beats (eight elements per beat, chunk 0..15); this also restarts
// the search. Then stream reference descriptors as req_type 1 beats; chunk 15
// closes a reference and, with last_ref set, produces one result beat holding
// the closest index, best and second distance, and whether
// best_weight*best < second_weight*second. One beat is taken every cycle
// while item.ready is high. The result for the beat that closes the list
// is made through a register stage, a squared-difference adder tree, the
// running search, a multiplier stage and an eight-entry result queue.
// item.ready drops only while eight results are owed and not yet delivered.
// Write best_weight / second_weight only while the block is idle.
module descriptor_ratio_test_matcher (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [drtm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [drtm_pkg::WEIGHT_W-1:0]    cfg_data,
	drtm_in_if.sink                               item,
	drtm_out_if.source                            result
);

	logic [drtm_pkg::WEIGHT_W-1:0]  best_weight_q;
	logic [drtm_pkg::WEIGHT_W-1:0]  second_weight_q;
	logic [drtm_pkg::CNT_W-1:0]     owed_q;

	logic                           accept;
	logic                           closes_list;
	logic                           out_beat;
	logic [drtm_pkg::ELEM_FIELDS-1:0][drtm_pkg::ELEM_W-1:0] all_elems;
	drtm_pkg::row_t                 in_row;
	drtm_pkg::lane_mask_t           lane_ok;
	logic [drtm_pkg::INDEX_W-1:0]   sat_index;
	logic [drtm_pkg::ROW_W-1:0]     row_addr;
	drtm_pkg::stage_ctl_t           ctl_in;

	drtm_pkg::stage_ctl_t           ctl_s1;
	drtm_pkg::row_t                 elem_s1;
	drtm_pkg::lane_mask_t           lane_ok_s1;
	drtm_pkg::row_t                 qry_s1;
	drtm_pkg::stage_ctl_t           ctl_s2;
	logic [drtm_pkg::SUM_W-1:0]     sum_s2;
	drtm_pkg::hit_t                 hit_s3;
	logic                           res_valid;
	drtm_pkg::out_beat_t            res;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_weight_q   <= drtm_pkg::BEST_WEIGHT_RST;
			second_weight_q <= drtm_pkg::SECOND_WEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				drtm_pkg::REG_BEST_WEIGHT:   best_weight_q   <= cfg_data;
				drtm_pkg::REG_SECOND_WEIGHT: second_weight_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign accept   = item.valid && item.ready;
	assign out_beat = result.valid && result.ready;

	assign all_elems = {item.data.elem_7, item.data.elem_6, item.data.elem_5,
	                    item.data.elem_4, item.data.elem_3, item.data.elem_2,
	                    item.data.elem_1, item.data.elem_0};

	always_comb begin
		logic [drtm_pkg::POS_W-1:0] pos;
		for (int i = 0; i < drtm_pkg::USED_LANES; i++) begin
			pos = drtm_pkg::POS_W'(item.data.chunk) * drtm_pkg::POS_W'(drtm_pkg::LANES)
			    + drtm_pkg::POS_W'(i);
			lane_ok[i] = (pos < drtm_pkg::POS_W'(drtm_pkg::DESC_LEN));
			in_row[i]  = all_elems[i];
		end
	end

	assign sat_index = (int'(item.data.ref_index) >= drtm_pkg::MAX_REFS)
	                 ? drtm_pkg::INDEX_W'(drtm_pkg::MAX_REFS - 1)
	                 : item.data.ref_index;
	assign row_addr  = drtm_pkg::ROW_W'(item.data.chunk);

	assign closes_list = (item.data.req_type == drtm_pkg::REQ_REF)
	                  && (int'(item.data.chunk) == drtm_pkg::LAST_CHUNK)
	                  && item.data.last_ref;

	always_comb begin
		ctl_in.valid      = accept;
		ctl_in.is_ref     = (item.data.req_type == drtm_pkg::REQ_REF);
		ctl_in.last_chunk = (int'(item.data.chunk) == drtm_pkg::LAST_CHUNK);
		ctl_in.last_ref   = item.data.last_ref;
		ctl_in.ref_index  = sat_index;
	end

	// results owed: list-closing beats accepted but not yet delivered
	assign item.ready = (owed_q < drtm_pkg::CNT_W'(drtm_pkg::FIFO_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q <= '0;
		end else begin
			case ({accept && closes_list, out_beat})
				2'b10:   owed_q <= owed_q + 1'b1;
				2'b01:   owed_q <= owed_q - 1'b1;
				default: owed_q <= owed_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		elem_s1    <= in_row;
		lane_ok_s1 <= lane_ok;
	end

	drtm_query_mem u_query_mem (
		.clk     (clk),
		.wr_en   (accept && (item.data.req_type == drtm_pkg::REQ_QUERY)),
		.lane_we (lane_ok),
		.rd_en   (accept && (item.data.req_type == drtm_pkg::REQ_REF)),
		.addr    (row_addr),
		.wr_data (in_row),
		.rd_data (qry_s1)
	);

	drtm_dist u_dist (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl_s1     (ctl_s1),
		.elem_s1    (elem_s1),
		.lane_ok_s1 (lane_ok_s1),
		.qry_s1     (qry_s1),
		.ctl_s2     (ctl_s2),
		.sum_s2     (sum_s2)
	);

	drtm_search u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_s2 (ctl_s2),
		.sum_s2 (sum_s2),
		.hit_s3 (hit_s3)
	);

	drtm_ratio u_ratio (
		.clk           (clk),
		.arst_n        (arst_n),
		.hit_s3        (hit_s3),
		.best_weight   (best_weight_q),
		.second_weight (second_weight_q),
		.res_valid     (res_valid),
		.res           (res)
	);

	drtm_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.result    (result)
	);

endmodule
`default_nettype wire
